[sv/lbp_pkg.sv]
// Shared types, constants and tables of the light bar pair feature block.
`default_nettype none
package lbp_pkg;

  localparam int CRD_W = 15;
  localparam int LEN_W = 16;
  localparam int DEF_COORD_FRAC_BITS = 4;
  localparam int CORDIC_STEPS = 18;

  localparam logic [9:0]  THR_RESET = 10'd77;
  localparam logic [9:0]  AR_MAX    = 10'd1023;
  localparam logic [8:0]  LR_FULL   = 9'd256;
  localparam logic [12:0] ANG_90    = 13'd5760;
  localparam logic [13:0] ANG_180   = 14'd11520;
  localparam logic [21:0] AREA_MAX  = 22'h3F_FFFF;

  typedef struct packed {
    logic [CRD_W-1:0] cx;
    logic [CRD_W-1:0] cy;
    logic [CRD_W-1:0] tx;
    logic [CRD_W-1:0] ty;
    logic [CRD_W-1:0] bx;
    logic [CRD_W-1:0] by;
    logic [LEN_W-1:0] len;
  } bar_t;

  function automatic logic [CRD_W-1:0] absd(input logic [CRD_W-1:0] a,
                                            input logic [CRD_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // arctangent of 2^-i in degrees * 65536
  function automatic logic [21:0] atan_tab(input logic [4:0] i);
    logic [21:0] t;
    case (i)
      5'd0:  t = 22'd2949120;
      5'd1:  t = 22'd1740967;
      5'd2:  t = 22'd919879;
      5'd3:  t = 22'd466945;
      5'd4:  t = 22'd234379;
      5'd5:  t = 22'd117304;
      5'd6:  t = 22'd58666;
      5'd7:  t = 22'd29335;
      5'd8:  t = 22'd14668;
      5'd9:  t = 22'd7334;
      5'd10: t = 22'd3667;
      5'd11: t = 22'd1833;
      5'd12: t = 22'd917;
      5'd13: t = 22'd458;
      5'd14: t = 22'd229;
      5'd15: t = 22'd115;
      5'd16: t = 22'd57;
      5'd17: t = 22'd29;
      default: t = 22'd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

[sv/lbp_mul.sv]
// Bit-serial shift-add multiplier for coordinate differences.
`default_nettype none
module lbp_mul
  import lbp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [CRD_W-1:0]     a,
  input  wire logic [CRD_W-1:0]     b,
  output logic                      done,
  output logic [2*CRD_W-1:0]        prod
);

  logic [2*CRD_W-1:0] acc_r;
  logic [2*CRD_W-1:0] mcand_r;
  logic [CRD_W-1:0]   mplier_r;
  logic [3:0]         cnt_r;
  logic               busy_r;
  logic               done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 4'(CRD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= {{CRD_W{1'b0}}, a};
      mplier_r <= b;
      cnt_r    <= '0;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[2*CRD_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[CRD_W-1:1]};
      cnt_r    <= cnt_r + 4'd1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

[sv/lbp_sqrt.sv]
// Iterative rounded square root, two radicand bits per cycle.
`default_nettype none
module lbp_sqrt
  import lbp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [30:0]   s,
  output logic               done,
  output logic [LEN_W-1:0]   root
);

  logic [31:0]      s_r;
  logic [31:0]      r_r;
  logic [31:0]      bit_r;
  logic [LEN_W-1:0] root_r;
  logic             busy_r;
  logic             done_r;
  logic [31:0]      trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s_r   <= {1'b0, s};
      r_r   <= '0;
      bit_r <= 32'h4000_0000;
    end else if (busy_r) begin
      if (bit_r != '0) begin
        if (s_r >= trial) begin
          s_r <= s_r - trial;
          r_r <= {1'b0, r_r[31:1]} + bit_r;
        end else begin
          r_r <= {1'b0, r_r[31:1]};
        end
        bit_r <= {2'b00, bit_r[31:2]};
      end else begin
        root_r <= (s_r > r_r) ? (r_r[LEN_W-1:0] + 16'd1) : r_r[LEN_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

[sv/lbp_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lbp_div
  import lbp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [24:0]      num,
  input  wire logic [LEN_W-1:0] den,
  output logic                  done,
  output logic [24:0]           quo
);

  logic [24:0]      quo_r;
  logic [LEN_W-1:0] rem_r;
  logic [LEN_W-1:0] den_r;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [LEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, quo_r[24]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd24) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? LEN_W'(trial - {1'b0, den_r}) : trial[LEN_W-1:0];
      quo_r <= {quo_r[23:0], ge};
      cnt_r <= cnt_r + 5'd1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

[sv/lbp_cordic.sv]
// Vectoring CORDIC arctangent of two magnitudes, one step per cycle.
`default_nettype none
module lbp_cordic
  import lbp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [CRD_W-1:0] ax,
  input  wire logic [CRD_W-1:0] ay,
  output logic                  done,
  output logic [12:0]           ang
);

  logic [33:0]        x_r;
  logic signed [34:0] y_r;
  logic signed [24:0] z_r;
  logic [4:0]         i_r;
  logic               zx_r;
  logic               zy_r;
  logic [12:0]        ang_r;
  logic               busy_r;
  logic               done_r;
  logic [33:0]        ymag;
  logic [33:0]        xs;
  logic [33:0]        ys;
  logic signed [24:0] t;
  logic signed [24:0] zr;

  assign ymag = y_r[34] ? 34'(-y_r) : y_r[33:0];
  assign xs   = x_r >> i_r;
  assign ys   = ymag >> i_r;
  assign t    = {3'b000, atan_tab(i_r)};
  assign zr   = (z_r + 25'sd512) >>> 10;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && i_r == 5'(CORDIC_STEPS)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r  <= {3'b000, ax, 16'b0};
      y_r  <= {4'b0000, ay, 16'b0};
      z_r  <= '0;
      i_r  <= '0;
      zx_r <= (ax == '0);
      zy_r <= (ay == '0);
    end else if (busy_r) begin
      if (i_r != 5'(CORDIC_STEPS)) begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - $signed({1'b0, xs});
          z_r <= z_r + t;
        end else if (y_r < 0) begin
          x_r <= x_r + ys;
          y_r <= y_r + $signed({1'b0, xs});
          z_r <= z_r - t;
        end
        i_r <= i_r + 5'd1;
      end else begin
        if (zy_r) begin
          ang_r <= '0;
        end else if (zx_r) begin
          ang_r <= ANG_90;
        end else if (z_r < 0) begin
          ang_r <= '0;
        end else if (zr > $signed({12'b0, ANG_90})) begin
          ang_r <= ANG_90;
        end else begin
          ang_r <= zr[12:0];
        end
      end
    end
  end

  assign done = done_r;
  assign ang  = ang_r;

endmodule
`default_nettype wire

[sv/light_bar_pair_features.sv]
// Light bar pair features: top level with pairing, sequencer and output register.
// A first bar is taken and gives no result.
// A pair's second bar starts the work: six serial products,
// two roots, two divisions and three CORDIC runs, done in turn on shared units.
// One pair is worked at a time; the next request is taken once the result is registered.
// Synchronous active-low reset drops the held bar, resets the sequencer and output valid, and sets the threshold to 77.
`default_nettype none
module light_bar_pair_features
  import lbp_pkg::*;
#(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [9:0]        cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CRD_W-1:0]  in_center_x,
  input  wire logic [CRD_W-1:0]  in_center_y,
  input  wire logic [CRD_W-1:0]  in_top_x,
  input  wire logic [CRD_W-1:0]  in_top_y,
  input  wire logic [CRD_W-1:0]  in_bottom_x,
  input  wire logic [CRD_W-1:0]  in_bottom_y,
  input  wire logic [LEN_W-1:0]  in_bar_length,
  input  wire logic              in_pair_end,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CRD_W-1:0]       out_mid_x,
  output logic [CRD_W-1:0]       out_mid_y,
  output logic [15:0]            out_height,
  output logic [15:0]            out_width,
  output logic [9:0]             out_aspect_ratio,
  output logic [21:0]            out_area,
  output logic [8:0]             out_length_ratio,
  output logic [12:0]            out_tilt_angle,
  output logic [13:0]            out_angle_mismatch,
  output logic                   out_is_big
);

  localparam int SH = 2 * COORD_FRAC_BITS + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_ATAN = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  state_r;
  logic [2:0]  idx_r;
  logic        issued_r;
  logic        held_valid_r;
  logic [9:0]  thr_r;
  bar_t        held_r, lb_r, rb_r, in_bar;

  logic [31:0]        sqh_r, sqw_r;
  logic signed [32:0] cross_r;
  logic [15:0]        h_r, w_r;
  logic [9:0]         ar_r;
  logic [8:0]         lr_r;
  logic [12:0]        tilt_r;
  logic [13:0]        angl_r, angr_r;

  logic               out_valid_r;
  logic [CRD_W-1:0]   mid_x_r, mid_y_r;
  logic [15:0]        oh_r, ow_r;
  logic [9:0]         oar_r;
  logic [21:0]        area_r;
  logic [8:0]         olr_r;
  logic [12:0]        otilt_r;
  logic [13:0]        mis_r;
  logic               big_r;

  logic               accept, load_out;
  logic [CRD_W-1:0]   mul_a, mul_b;
  logic               mul_start, mul_done;
  logic [2*CRD_W-1:0] prod;
  logic               mul_neg;
  logic signed [32:0] term;
  logic [30:0]        sq_in;
  logic               sqrt_start, sqrt_done;
  logic [15:0]        root;
  logic [24:0]        div_num, div_quo;
  logic [15:0]        div_den;
  logic               div_zero, div_start, div_done;
  logic [CRD_W-1:0]   cd_ax, cd_ay;
  logic               cd_flip, cd_start, cd_done;
  logic [12:0]        cd_ang;
  logic [15:0]        len_mn, len_mx;
  bar_t               ab;
  logic [32:0]        mag;
  logic [33:0]        area_sum, area_sh;
  logic [15:0]        sum_x, sum_y;

  assign in_bar   = '{cx: in_center_x, cy: in_center_y, tx: in_top_x, ty: in_top_y,
                      bx: in_bottom_x, by: in_bottom_y, len: in_bar_length};
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  assign len_mn = (lb_r.len < rb_r.len) ? lb_r.len : rb_r.len;
  assign len_mx = (lb_r.len < rb_r.len) ? rb_r.len : lb_r.len;
  assign ab     = (idx_r == 3'd1) ? lb_r : rb_r;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (idx_r)
      3'd0: begin
        mul_a = absd(lb_r.tx, lb_r.bx);
        mul_b = mul_a;
      end
      3'd1: begin
        mul_a = absd(lb_r.ty, lb_r.by);
        mul_b = mul_a;
      end
      3'd2: begin
        mul_a = absd(lb_r.bx, rb_r.bx);
        mul_b = mul_a;
      end
      3'd3: begin
        mul_a = absd(lb_r.by, rb_r.by);
        mul_b = mul_a;
      end
      3'd4: begin
        mul_a   = absd(lb_r.bx, rb_r.tx);
        mul_b   = absd(lb_r.ty, rb_r.by);
        mul_neg = (lb_r.bx < rb_r.tx) != (lb_r.ty < rb_r.by);
      end
      3'd5: begin
        mul_a   = absd(lb_r.tx, rb_r.bx);
        mul_b   = absd(lb_r.by, rb_r.ty);
        mul_neg = (lb_r.tx < rb_r.bx) == (lb_r.by < rb_r.ty);
      end
      default: ;
    endcase
  end

  assign term = mul_neg ? -$signed({3'b000, prod}) : $signed({3'b000, prod});

  assign sq_in = (idx_r == 3'd0) ? sqh_r[30:0] : sqw_r[30:0];

  always_comb begin
    if (idx_r == 3'd0) begin
      div_num  = {1'b0, h_r, 8'b0} + 25'(w_r[15:1]);
      div_den  = w_r;
      div_zero = (w_r == '0);
    end else begin
      div_num  = {1'b0, len_mn, 8'b0} + 25'(len_mx[15:1]);
      div_den  = len_mx;
      div_zero = (len_mx == '0);
    end
  end

  always_comb begin
    if (idx_r == 3'd0) begin
      cd_ax = absd(lb_r.cx, rb_r.cx);
      cd_ay = absd(lb_r.cy, rb_r.cy);
    end else begin
      cd_ax = absd(ab.tx, ab.bx);
      cd_ay = absd(ab.ty, ab.by);
    end
  end
  assign cd_flip = ((ab.tx > ab.bx) != (ab.ty > ab.by)) && (ab.tx != ab.bx)
                   && (ab.ty != ab.by);

  assign mul_start  = (state_r == ST_MUL)  && !issued_r;
  assign sqrt_start = (state_r == ST_SQRT) && !issued_r;
  assign div_start  = (state_r == ST_DIV)  && !issued_r && !div_zero;
  assign cd_start   = (state_r == ST_ATAN) && !issued_r;

  lbp_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(prod)
  );

  lbp_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .s(sq_in),
    .done(sqrt_done), .root(root)
  );

  lbp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  lbp_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cd_start), .ax(cd_ax), .ay(cd_ay),
    .done(cd_done), .ang(cd_ang)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      issued_r     <= 1'b0;
      held_valid_r <= 1'b0;
      thr_r        <= THR_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (!in_pair_end) begin
              held_valid_r <= 1'b1;
            end else if (held_valid_r) begin
              held_valid_r <= 1'b0;
              state_r      <= ST_MUL;
              idx_r        <= '0;
              issued_r     <= 1'b0;
            end
          end
        end
        ST_MUL: begin
          if (mul_start) begin
            issued_r <= 1'b1;
          end else if (mul_done) begin
            issued_r <= 1'b0;
            if (idx_r == 3'd5) begin
              state_r <= ST_SQRT;
              idx_r   <= '0;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end
        ST_SQRT: begin
          if (sqrt_start) begin
            issued_r <= 1'b1;
          end else if (sqrt_done) begin
            issued_r <= 1'b0;
            if (idx_r == 3'd1) begin
              state_r <= ST_DIV;
              idx_r   <= '0;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end
        ST_DIV: begin
          if (div_start) begin
            issued_r <= 1'b1;
          end else if (div_done || (!issued_r && div_zero)) begin
            issued_r <= 1'b0;
            if (idx_r == 3'd1) begin
              state_r <= ST_ATAN;
              idx_r   <= '0;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end
        ST_ATAN: begin
          if (cd_start) begin
            issued_r <= 1'b1;
          end else if (cd_done) begin
            issued_r <= 1'b0;
            if (idx_r == 3'd2) begin
              state_r <= ST_OUT;
              idx_r   <= '0;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end
        ST_OUT: begin
          if (load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!in_pair_end) begin
        held_r <= in_bar;
      end else if (held_r.cx <= in_bar.cx) begin
        lb_r <= held_r;
        rb_r <= in_bar;
      end else begin
        lb_r <= in_bar;
        rb_r <= held_r;
      end
    end
    if (state_r == ST_MUL && mul_done) begin
      case (idx_r)
        3'd0: sqh_r <= {2'b00, prod};
        3'd1: sqh_r <= sqh_r + {2'b00, prod};
        3'd2: sqw_r <= {2'b00, prod};
        3'd3: sqw_r <= sqw_r + {2'b00, prod};
        3'd4: cross_r <= term;
        default: cross_r <= cross_r + term;
      endcase
    end
    if (state_r == ST_SQRT && sqrt_done) begin
      if (idx_r == 3'd0) begin
        h_r <= root;
      end else begin
        w_r <= root;
      end
    end
    if (state_r == ST_DIV) begin
      if (idx_r == 3'd0) begin
        if (!issued_r && div_zero) begin
          ar_r <= AR_MAX;
        end else if (div_done) begin
          ar_r <= (div_quo > 25'(AR_MAX)) ? AR_MAX : div_quo[9:0];
        end
      end else begin
        if (!issued_r && div_zero) begin
          lr_r <= LR_FULL;
        end else if (div_done) begin
          lr_r <= div_quo[8:0];
        end
      end
    end
    if (state_r == ST_ATAN && cd_done) begin
      case (idx_r)
        3'd0: tilt_r <= cd_ang;
        3'd1: angl_r <= cd_flip ? (ANG_180 - {1'b0, cd_ang}) : {1'b0, cd_ang};
        default: angr_r <= cd_flip ? (ANG_180 - {1'b0, cd_ang}) : {1'b0, cd_ang};
      endcase
    end
  end

  assign mag      = cross_r[32] ? 33'(-cross_r) : cross_r;
  assign area_sum = {1'b0, mag} + (34'd1 << (SH - 1));
  assign area_sh  = area_sum >> SH;
  assign sum_x    = {1'b0, lb_r.cx} + {1'b0, rb_r.cx};
  assign sum_y    = {1'b0, lb_r.cy} + {1'b0, rb_r.cy};

  always_ff @(posedge clk) begin
    if (load_out) begin
      mid_x_r <= sum_x[15:1];
      mid_y_r <= sum_y[15:1];
      oh_r    <= h_r;
      ow_r    <= w_r;
      oar_r   <= ar_r;
      area_r  <= (area_sh > 34'(AREA_MAX)) ? AREA_MAX : area_sh[21:0];
      olr_r   <= lr_r;
      otilt_r <= tilt_r;
      mis_r   <= (angl_r > angr_r) ? (angl_r - angr_r) : (angr_r - angl_r);
      big_r   <= (ar_r < thr_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mid_x          = mid_x_r;
  assign out_mid_y          = mid_y_r;
  assign out_height         = oh_r;
  assign out_width          = ow_r;
  assign out_aspect_ratio   = oar_r;
  assign out_area           = area_r;
  assign out_length_ratio   = olr_r;
  assign out_tilt_angle     = otilt_r;
  assign out_angle_mismatch = mis_r;
  assign out_is_big         = big_r;

endmodule
`default_nettype wire
